>>> rtl/ccsr_pkg.sv
package ccsr_pkg;

  // Sizing of the row table and the column store
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned ROW_AW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_AW      = $clog2(MAX_ENTRIES);

  // Field widths
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ROW_W  = 11;
  localparam int unsigned COL_W  = 11;
  localparam int unsigned VAL_W  = 13;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 11;

  localparam logic [ROW_W-1:0] NUM_ROWS_RST = ROW_W'(1024);

  localparam logic [CFG_AW-1:0] CFG_NUM_ROWS = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_ORIGIN   = CFG_AW'(1);

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 3'd0,
    FN_COUNT  = 3'd1,
    FN_FINAL  = 3'd2,
    FN_PLACE  = 3'd3,
    FN_RD_PTR = 3'd4,
    FN_RD_COL = 3'd5
  } ccsr_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_ROW_RANGE   = 2'd1,
    ST_INDEX_RANGE = 2'd2,
    ST_FULL        = 2'd3
  } ccsr_status_e;

  typedef struct packed {
    logic [ROW_W-1:0] num_rows;
    logic             origin;
  } ccsr_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ROW_AW-1:0] raddr;
  } ccsr_row_req_t;

  typedef struct packed {
    logic              we;
    logic [COL_AW-1:0] waddr;
    logic [COL_W-1:0]  wdata;
    logic [COL_AW-1:0] raddr;
  } ccsr_col_req_t;

endpackage

>>> rtl/ccsr_ram.sv
module ccsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ccsr_seq.sv
module ccsr_seq
  import ccsr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [ROW_W-1:0]    row_index_i,
  input  logic [COL_W-1:0]    col_index_i,
  input  logic [VAL_W-1:0]    read_index_i,
  input  ccsr_cfg_t           cfg_i,
  output ccsr_row_req_t       row_req_o,
  input  logic [VAL_W-1:0]    row_rdata_i,
  output ccsr_col_req_t       col_req_o,
  input  logic [COL_W-1:0]    col_rdata_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [VAL_W-1:0]    result_value_o,
  output logic [STAT_W-1:0]   status_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FIN,
    S_CLR
  } state_e;

  state_e            state_q, state_d;
  ccsr_func_e        func_q, func_d;
  ccsr_status_e      st_q, st_d, st_pre;
  logic [ROW_AW-1:0] raddr_q, raddr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              ptr_zero_q, ptr_zero_d;
  logic [ROW_AW-1:0] idx_q, idx_d;
  logic [VAL_W-1:0]  sum_q, sum_d;
  logic [VAL_W-1:0]  entry_count_q, entry_count_d;
  logic              done_q, done_d;
  logic [VAL_W-1:0]  result_q, result_d;
  ccsr_status_e      status_q, status_d;

  logic [ROW_W-1:0]  n_rows;
  logic [ROW_W-1:0]  row_sub;
  logic              row_ok, ptr_ok, col_ok, accept;
  logic [VAL_W-1:0]  base_v;
  logic [VAL_W-1:0]  p_sub;
  logic [ROW_AW-1:0] row_raddr;

  assign n_rows  = (cfg_i.num_rows > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : cfg_i.num_rows;
  assign base_v  = VAL_W'(cfg_i.origin);
  assign row_sub = row_index_i - ROW_W'(cfg_i.origin);
  assign row_ok  = (row_index_i >= ROW_W'(cfg_i.origin)) && (row_sub < n_rows);
  assign ptr_ok  = read_index_i <= VAL_W'(n_rows);
  assign col_ok  = (read_index_i < entry_count_q) && (read_index_i < VAL_W'(MAX_ENTRIES));
  assign accept  = start_i && (state_q == S_IDLE);
  assign p_sub   = row_rdata_i - base_v;

  // Early checks, resolved before the table is read
  always_comb begin
    st_pre = ST_OK;
    unique case (func_i)
      FN_COUNT: begin
        if (!row_ok) begin
          st_pre = ST_ROW_RANGE;
        end else if (entry_count_q >= VAL_W'(MAX_ENTRIES)) begin
          st_pre = ST_FULL;
        end
      end
      FN_PLACE: begin
        if (!row_ok) begin
          st_pre = ST_ROW_RANGE;
        end
      end
      FN_RD_PTR: begin
        if (!ptr_ok) begin
          st_pre = ST_INDEX_RANGE;
        end
      end
      FN_RD_COL: begin
        if (!col_ok) begin
          st_pre = ST_INDEX_RANGE;
        end
      end
      default: st_pre = ST_OK;
    endcase
  end

  // Row table read address
  always_comb begin
    if (state_q == S_FIN) begin
      row_raddr = idx_q + ROW_AW'(1);
    end else if (func_i == FN_RD_PTR) begin
      row_raddr = ROW_AW'(read_index_i - VAL_W'(1));
    end else if (func_i == FN_FINAL) begin
      row_raddr = '0;
    end else begin
      row_raddr = ROW_AW'(row_sub);
    end
  end

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    st_d          = st_q;
    raddr_d       = raddr_q;
    col_d         = col_q;
    ptr_zero_d    = ptr_zero_q;
    idx_d         = idx_q;
    sum_d         = sum_q;
    entry_count_d = entry_count_q;
    done_d        = 1'b0;
    result_d      = result_q;
    status_d      = status_q;

    row_req_o.we    = 1'b0;
    row_req_o.waddr = raddr_q;
    row_req_o.wdata = '0;
    row_req_o.raddr = row_raddr;
    col_req_o.we    = 1'b0;
    col_req_o.waddr = COL_AW'(p_sub);
    col_req_o.wdata = col_q;
    col_req_o.raddr = COL_AW'(read_index_i);

    unique case (state_q)
      S_INIT, S_CLR: begin
        row_req_o.we    = 1'b1;
        row_req_o.waddr = idx_q;
        if (idx_q == ROW_AW'(MAX_ROWS)) begin
          idx_d         = '0;
          entry_count_d = '0;
          state_d       = S_IDLE;
          if (state_q == S_CLR) begin
            done_d   = 1'b1;
            result_d = '0;
            status_d = ST_OK;
          end
        end else begin
          idx_d = idx_q + ROW_AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          func_d     = ccsr_func_e'(func_i);
          st_d       = st_pre;
          raddr_d    = row_raddr;
          col_d      = col_index_i;
          ptr_zero_d = (read_index_i == '0);
          idx_d      = '0;
          sum_d      = base_v;
          if (func_i == FN_CLEAR) begin
            state_d = S_CLR;
          end else if (func_i == FN_FINAL) begin
            state_d = S_FIN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        done_d   = 1'b1;
        result_d = '0;
        status_d = st_q;
        state_d  = S_IDLE;
        if (st_q == ST_OK) begin
          unique case (func_q)
            FN_COUNT: begin
              row_req_o.we    = 1'b1;
              row_req_o.wdata = row_rdata_i + VAL_W'(1);
              entry_count_d   = entry_count_q + VAL_W'(1);
              result_d        = entry_count_q + VAL_W'(1);
            end
            FN_PLACE: begin
              if ((row_rdata_i < base_v) || (p_sub >= VAL_W'(MAX_ENTRIES))) begin
                status_d = ST_FULL;
              end else begin
                col_req_o.we    = 1'b1;
                row_req_o.we    = 1'b1;
                row_req_o.wdata = row_rdata_i + VAL_W'(1);
                result_d        = p_sub;
              end
            end
            FN_RD_PTR: result_d = ptr_zero_q ? base_v : row_rdata_i;
            FN_RD_COL: result_d = VAL_W'(col_rdata_i);
            default:   result_d = '0;
          endcase
        end
      end
      S_FIN: begin
        row_req_o.we    = 1'b1;
        row_req_o.waddr = idx_q;
        if (idx_q == ROW_AW'(n_rows)) begin
          // closing pointer
          row_req_o.wdata = entry_count_q + base_v;
          done_d          = 1'b1;
          result_d        = entry_count_q;
          status_d        = ST_OK;
          state_d         = S_IDLE;
        end else begin
          row_req_o.wdata = sum_q;
          sum_d           = sum_q + row_rdata_i;
          idx_d           = idx_q + ROW_AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      func_q        <= FN_CLEAR;
      st_q          <= ST_OK;
      raddr_q       <= '0;
      col_q         <= '0;
      ptr_zero_q    <= 1'b0;
      idx_q         <= '0;
      sum_q         <= '0;
      entry_count_q <= '0;
      done_q        <= 1'b0;
      result_q      <= '0;
      status_q      <= ST_OK;
    end else begin
      state_q       <= state_d;
      func_q        <= func_d;
      st_q          <= st_d;
      raddr_q       <= raddr_d;
      col_q         <= col_d;
      ptr_zero_q    <= ptr_zero_d;
      idx_q         <= idx_d;
      sum_q         <= sum_d;
      entry_count_q <= entry_count_d;
      done_q        <= done_d;
      result_q      <= result_d;
      status_q      <= status_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= VAL_W'(MAX_ENTRIES))
    else $error("entry count beyond store size");

  a_fin_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && row_req_o.we) |-> (row_req_o.raddr != row_req_o.waddr))
    else $error("prefix walk reads the row it writes");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && idx_q == ROW_AW'(MAX_ROWS)) |=> (done_q && entry_count_q == '0))
    else $error("clear did not finish cleanly");

endmodule

>>> rtl/coo_to_csr_converter_top.sv
// Count, place, read and unused codes go from start through S_EXEC to a registered done_o.
// A new transaction is taken only in idle, once the row table read-modify-write has ended.
// Finalize walks the rows in use and writes the closing pointer; clear sweeps the table.
// Reset: a clearing pass over every entry of the row table runs with busy high; config is
// taken at any time. done_o pulses one cycle per transaction; the receiver cannot stall.
module coo_to_csr_converter_top
  import ccsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ROW_W-1:0]  row_index_i,
  input  logic [COL_W-1:0]  col_index_i,
  input  logic [VAL_W-1:0]  read_index_i,
  // result channel
  output logic              done_o,
  output logic [VAL_W-1:0]  result_value_o,
  output logic [STAT_W-1:0] status_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  logic [ROW_W-1:0] num_rows_q, num_rows_d;
  logic             origin_q, origin_d;
  ccsr_cfg_t        cfg;

  ccsr_row_req_t    row_req;
  logic [VAL_W-1:0] row_rdata;
  ccsr_col_req_t    col_req;
  logic [COL_W-1:0] col_rdata;

  // Config registers; writes to unknown indices are dropped
  always_comb begin
    num_rows_d = num_rows_q;
    origin_d   = origin_q;
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_NUM_ROWS) begin
        num_rows_d = cfg_data_i[ROW_W-1:0];
      end else if (cfg_index_i == CFG_ORIGIN) begin
        origin_d = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NUM_ROWS_RST;
      origin_q   <= 1'b0;
    end else begin
      num_rows_q <= num_rows_d;
      origin_q   <= origin_d;
    end
  end

  assign cfg.num_rows = num_rows_q;
  assign cfg.origin   = origin_q;

  // Sequencer: decodes func, runs the read-modify-write and the table walks
  ccsr_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .func_i         (func_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .read_index_i   (read_index_i),
    .cfg_i          (cfg),
    .row_req_o      (row_req),
    .row_rdata_i    (row_rdata),
    .col_req_o      (col_req),
    .col_rdata_i    (col_rdata),
    .busy_o         (busy),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  // Row table: counts, then start pointers, then next-free pointers
  ccsr_ram #(
    .Width (VAL_W),
    .Depth (MAX_ROWS + 1)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_req.we),
    .waddr_i (row_req.waddr),
    .wdata_i (row_req.wdata),
    .raddr_i (row_req.raddr),
    .rdata_o (row_rdata)
  );

  // Column store, indexed by zero-based CSR position
  ccsr_ram #(
    .Width (COL_W),
    .Depth (MAX_ENTRIES)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_req.we),
    .waddr_i (col_req.waddr),
    .wdata_i (col_req.wdata),
    .raddr_i (col_req.raddr),
    .rdata_o (col_rdata)
  );

endmodule
